// ----- design/kalt_pkg.sv -----
// ----------------------------------------------------------------------------
// kalt_pkg: keyed array list table shared definitions
// Field widths, operation and status codes, entry layout and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package kalt_pkg;

  localparam int MODE_W      = 2;
  localparam int CODE_W      = 31;
  localparam int QTY_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int S_TDATA_W   = 96;
  localparam int M_TDATA_W   = 16;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;
  localparam mode_t MODE_UPDATE = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [QTY_W-1:0]  qty;
  } entry_t;

  typedef struct packed {
    logic load;
    logic run;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

endpackage

// ----- design/kalt_ctrl.sv -----
// ----------------------------------------------------------------------------
// kalt_ctrl: request sequencer
// Takes one request at a time, runs the datapath pass and hands the result
// to the output register when it is free.
// ----------------------------------------------------------------------------
module kalt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output kalt_pkg::cmd_t  cmd,
  input  kalt_pkg::stat_t st
);
  import kalt_pkg::*;

  typedef enum logic {IDLE, EXEC} state_t;

  state_t state;
  logic   out_valid;

  assign s_tready = (state == IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd.load   = s_tvalid && (state == IDLE);
    cmd.run    = (state == EXEC);
    cmd.commit = (state == EXEC) && st.done && (!out_valid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.load) state <= EXEC;
        end
        EXEC: begin
          if (cmd.commit) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/kalt_dpath.sv -----
// ----------------------------------------------------------------------------
// kalt_dpath: entry store and scan datapath
// Holds the entry memory and fill count, scans entries one a cycle through a
// registered read port, rewrites matches and shifts entries down on delete.
// ----------------------------------------------------------------------------
module kalt_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  kalt_pkg::cmd_t                       cmd,
  output kalt_pkg::stat_t                      st,
  input  kalt_pkg::mode_t                      mode,
  input  logic [kalt_pkg::CODE_W-1:0]          key_code,
  input  logic [kalt_pkg::CODE_W-1:0]          new_code,
  input  logic signed [kalt_pkg::QTY_W-1:0]    quantity,
  output logic                                 found,
  output kalt_pkg::status_t                    status,
  output logic [kalt_pkg::COUNT_OUT_W-1:0]     entry_count
);
  import kalt_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  entry_t mem [CAPACITY];

  mode_t             mode_r;
  logic [CODE_W-1:0] key_r;
  logic [CODE_W-1:0] ncode_r;
  logic [QTY_W-1:0]  qty_r;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] ptr;
  logic [IW-1:0] cmp_idx;
  logic          cmp_vld;
  logic          hit;
  entry_t        rd_data;

  logic          full;
  logic          issue;
  logic          match;
  logic          we;
  logic [IW-1:0] wa;
  entry_t        wd;
  status_t       status_next;

  assign full    = (count == CW'(CAPACITY));
  assign issue   = cmd.run && (mode_r != MODE_APPEND) && (ptr != count);
  assign match   = cmp_vld && (rd_data.code == key_r);
  assign st.done = (mode_r == MODE_APPEND) || ((ptr == count) && !cmp_vld);

  always_comb begin
    we = 1'b0;
    wa = cmp_idx;
    wd = rd_data;
    unique case (mode_r)
      MODE_APPEND: begin
        we = cmd.run && !full;
        wa = count[IW-1:0];
        wd = '{code: key_r, qty: qty_r};
      end
      MODE_UPDATE: begin
        we = cmd.run && match;
        wd = '{code: ncode_r, qty: qty_r};
      end
      MODE_DELETE: begin
        we = cmd.run && cmp_vld && hit;
        wa = cmp_idx - 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    count_next  = count;
    status_next = hit ? ST_OK : ST_MISSING;
    unique case (mode_r)
      MODE_APPEND: begin
        status_next = full ? ST_FULL : ST_OK;
        if (!full) count_next = count + 1'b1;
      end
      MODE_DELETE: begin
        if (hit) count_next = count - 1'b1;
      end
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (issue) rd_data <= mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode;
      key_r   <= key_code;
      ncode_r <= new_code;
      qty_r   <= quantity;
    end
    if (issue) cmp_idx <= ptr[IW-1:0];
    if (cmd.commit) begin
      found       <= hit && (mode_r != MODE_APPEND);
      status      <= status_next;
      entry_count <= COUNT_OUT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ptr     <= '0;
      cmp_vld <= 1'b0;
      hit     <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr     <= '0;
        cmp_vld <= 1'b0;
        hit     <= 1'b0;
      end else begin
        if (issue) ptr <= ptr + 1'b1;
        cmp_vld <= issue;
        if (match) hit <= 1'b1;
      end
      if (cmd.commit) count <= count_next;
    end
  end

endmodule

// ----- design/keyed_array_list_table.sv -----
// ----------------------------------------------------------------------------
// keyed_array_list_table: packed list of code and quantity entries
// Append, search, delete-first and update-all requests over a list held in
// one memory, with one result per request.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: tuser carries the mode, tdata the key
// code, the new code and the quantity. Each request gives one result on the
// m_ channel with the found flag, the status and the entry count.
// One request is in work at a time. Search, delete and update walk the n
// held entries through the memory's registered read port, one entry a
// cycle; delete shifts the later entries down in the same pass. The next
// request can be taken in the cycle after the result is loaded.
// The result sits in an output register; a new request is accepted while it
// waits, and that request's pass holds at its end until the register frees.
// Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_array_list_table #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // key_code[30:0], new_code[61:31], quantity[93:62], zero fill
  input  logic [kalt_pkg::S_TDATA_W-1:0]     s_tdata,
  // mode[1:0]
  input  logic [kalt_pkg::MODE_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // found[0], status[2:1], entry_count[9:3], zero fill
  output logic [kalt_pkg::M_TDATA_W-1:0]     m_tdata
);
  import kalt_pkg::*;

  cmd_t                     cmd;
  stat_t                    st;
  logic                     found;
  status_t                  status;
  logic [COUNT_OUT_W-1:0]   entry_count;

  kalt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st)
  );

  kalt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mode        (s_tuser),
    .key_code    (s_tdata[CODE_W-1:0]),
    .new_code    (s_tdata[2*CODE_W-1:CODE_W]),
    .quantity    ($signed(s_tdata[2*CODE_W+QTY_W-1:2*CODE_W])),
    .found       (found),
    .status      (status),
    .entry_count (entry_count)
  );

  assign m_tdata = {(M_TDATA_W - COUNT_OUT_W - STATUS_W - 1)'(0), entry_count, status, found};

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[2:1] == ST_OK)
    else $error("found result without ok status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:1] == ST_OK || m_tdata[2:1] == ST_FULL ||
                 m_tdata[2:1] == ST_MISSING)
    else $error("result status out of range");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in work");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: keyed array list table testbench
// Drives append, search, delete and update requests into the list and checks
// every result against a behavioural copy of the list held in the bench or a
// typed row. A directed table covers the empty and full list, extreme codes
// and quantities and duplicate codes. Random requests follow, biased towards
// codes already held, under four idle and stall patterns on the two streams.
// ----------------------------------------------------------------------------
module tb_top;
  import kalt_pkg::*;

  localparam int CAPACITY = 64;
  localparam int RANDOM_PER_PHASE = 340;
  localparam logic [CODE_W-1:0] CODE_MAX = 31'h7FFF_FFFF;
  localparam logic [QTY_W-1:0] QTY_MIN = 32'h8000_0000;
  localparam logic [QTY_W-1:0] QTY_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    status_t                status;
    logic                   found;
  } list_result_t;

  typedef struct {
    mode_t             op;
    logic [CODE_W-1:0] key;
    logic [CODE_W-1:0] ncode;
    logic [QTY_W-1:0]  qty;
  } list_req_t;

  typedef struct {
    mode_t                  op;
    logic [CODE_W-1:0]      key;
    logic [CODE_W-1:0]      ncode;
    logic [QTY_W-1:0]       qty;
    int                     reps;
    bit                     typed;
    logic                   found;
    status_t                status;
    logic [COUNT_OUT_W-1:0] count;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [MODE_W-1:0]    s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  logic [CODE_W-1:0] held_codes[CAPACITY];
  logic [QTY_W-1:0]  held_qtys[CAPACITY];
  int                held_fill;

  list_result_t pending_results[$];
  logic [CODE_W-1:0] code_pool[8];
  dir_row_t directed_rows[25];

  int src_idle_pct;
  int sink_stall_pct;
  int errors;
  int requests_sent;
  int results_checked;
  int peak_fill;
  int full_appends;
  int key_misses;

  keyed_array_list_table #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic list_result_t apply_list_op(list_req_t rq);
    list_result_t r;
    int k;
    int hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (rq.op)
      MODE_APPEND: begin
        if (held_fill >= CAPACITY) begin
          r.status = ST_FULL;
          full_appends++;
        end else begin
          held_codes[held_fill] = rq.key;
          held_qtys[held_fill] = rq.qty;
          held_fill++;
        end
      end
      MODE_SEARCH: begin
        for (k = 0; k < held_fill; k++)
          if (held_codes[k] == rq.key) r.found = 1'b1;
      end
      MODE_DELETE: begin
        for (k = 0; k < held_fill && hit < 0; k++)
          if (held_codes[k] == rq.key) hit = k;
        if (hit >= 0) begin
          r.found = 1'b1;
          for (k = hit; k + 1 < held_fill; k++) begin
            held_codes[k] = held_codes[k + 1];
            held_qtys[k] = held_qtys[k + 1];
          end
          held_fill--;
        end
      end
      default: begin
        for (k = 0; k < held_fill; k++)
          if (held_codes[k] == rq.key) begin
            r.found = 1'b1;
            held_codes[k] = rq.ncode;
            held_qtys[k] = rq.qty;
          end
      end
    endcase
    if (rq.op != MODE_APPEND && !r.found) begin
      r.status = ST_MISSING;
      key_misses++;
    end
    if (held_fill > peak_fill) peak_fill = held_fill;
    r.count = held_fill[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] random_code();
    case ($urandom_range(15))
      0: return '0;
      1: return CODE_MAX;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  task automatic issue_request(input list_req_t rq, input bit typed, input list_result_t typed_res);
    list_result_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, rq.qty, rq.ncode, rq.key};
    s_tuser <= rq.op;
    do @(posedge clk); while (!s_tready);
    pred = apply_list_op(rq);
    pending_results.push_back(typed ? typed_res : pred);
    requests_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[9:0];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0b status=%0d count=%0d",
                 $time, got.found, got.status, got.count);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.found !== want.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.count !== want.count) begin
          errors++;
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count, got.count);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    list_req_t rq;
    list_result_t tr;
    int ph;
    int i;
    int r;
    int append_pct;
    int src_pcts[4];
    int sink_pcts[4];

    src_pcts = '{0, 68, 0, 28};
    sink_pcts = '{0, 0, 68, 28};
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    errors = 0;
    requests_sent = 0;
    results_checked = 0;
    peak_fill = 0;
    full_appends = 0;
    key_misses = 0;
    held_fill = 0;
    for (i = 0; i < 8; i++) code_pool[i] = random_code();

    directed_rows = '{
      '{MODE_SEARCH, 31'd0,        31'd0,        32'd0,     1, 1'b1, 1'b0, ST_MISSING, 7'd0},
      '{MODE_DELETE, CODE_MAX,     31'd0,        32'd0,     1, 1'b1, 1'b0, ST_MISSING, 7'd0},
      '{MODE_UPDATE, 31'd5,        31'd9,        32'd1,     1, 1'b1, 1'b0, ST_MISSING, 7'd0},
      '{MODE_APPEND, CODE_MAX,     31'd0,        QTY_MIN,   1, 1'b1, 1'b0, ST_OK,      7'd1},
      '{MODE_APPEND, 31'd0,        CODE_MAX,     QTY_MAX,   1, 1'b1, 1'b0, ST_OK,      7'd2},
      '{MODE_APPEND, CODE_MAX,     31'd0,        32'd0,     1, 1'b1, 1'b0, ST_OK,      7'd3},
      '{MODE_SEARCH, CODE_MAX,     31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd3},
      '{MODE_SEARCH, 31'd1,        31'd0,        32'd0,     1, 1'b1, 1'b0, ST_MISSING, 7'd3},
      '{MODE_UPDATE, CODE_MAX, 31'h2AAAAAAA, 32'hFFFFFFFF,  1, 1'b1, 1'b1, ST_OK,      7'd3},
      '{MODE_SEARCH, CODE_MAX,     31'd0,        32'd0,     1, 1'b1, 1'b0, ST_MISSING, 7'd3},
      '{MODE_DELETE, 31'h2AAAAAAA, 31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd2},
      '{MODE_SEARCH, 31'h2AAAAAAA, 31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd2},
      '{MODE_DELETE, 31'd0,        31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd1},
      '{MODE_DELETE, 31'h2AAAAAAA, 31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd0},
      '{MODE_APPEND, 31'h55555555, 31'd0,     32'h55555555, 1, 1'b1, 1'b0, ST_OK,      7'd1},
      '{MODE_UPDATE, 31'h55555555, 31'd0,     32'hAAAAAAAA, 1, 1'b1, 1'b1, ST_OK,      7'd1},
      '{MODE_DELETE, 31'd0,        31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd0},
      '{MODE_APPEND, 31'd100,      31'd0,        32'd0, CAPACITY, 1'b0, 1'b0, ST_OK,   7'd0},
      '{MODE_APPEND, 31'd7,        31'd0,        32'd0,     1, 1'b1, 1'b0, ST_FULL,    7'd64},
      '{MODE_SEARCH, 31'd163,      31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd64},
      '{MODE_DELETE, 31'd100,      31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd63},
      '{MODE_SEARCH, 31'd163,      31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd63},
      '{MODE_APPEND, CODE_MAX,     31'd0,        32'd3,     1, 1'b1, 1'b0, ST_OK,      7'd64},
      '{MODE_DELETE, CODE_MAX,     31'd0,        32'd0,     1, 1'b1, 1'b1, ST_OK,      7'd63},
      '{MODE_UPDATE, 31'd130,      CODE_MAX,     32'd123,   1, 1'b1, 1'b1, ST_OK,      7'd63}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct = src_pcts[ph];
      sink_stall_pct = sink_pcts[ph];
      if (ph == 0) begin
        foreach (directed_rows[d]) begin
          for (r = 0; r < directed_rows[d].reps; r++) begin
            rq.op = directed_rows[d].op;
            rq.key = directed_rows[d].key + CODE_W'(r);
            rq.ncode = directed_rows[d].ncode;
            rq.qty = (directed_rows[d].reps > 1) ? 32'($urandom) : directed_rows[d].qty;
            tr.found = directed_rows[d].found;
            tr.status = directed_rows[d].status;
            tr.count = directed_rows[d].count;
            issue_request(rq, directed_rows[d].typed, tr);
          end
        end
      end
      append_pct = 50;
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        // drift the append share so the list swings between empty and full
        if (i % 85 == 0) append_pct = $urandom_range(15, 75);
        if ($urandom_range(31) == 0) code_pool[$urandom_range(7)] = random_code();
        rq.qty = $urandom;
        rq.ncode = $urandom_range(1) ? code_pool[$urandom_range(7)] : random_code();
        if ($urandom_range(99) < append_pct) begin
          rq.op = MODE_APPEND;
          rq.key = $urandom_range(2) ? code_pool[$urandom_range(7)] : random_code();
        end else begin
          case ($urandom_range(2))
            0: rq.op = MODE_SEARCH;
            1: rq.op = MODE_DELETE;
            default: rq.op = MODE_UPDATE;
          endcase
          if (held_fill > 0 && $urandom_range(9) < 7)
            rq.key = held_codes[$urandom_range(held_fill - 1)];
          else
            rq.key = $urandom_range(1) ? code_pool[$urandom_range(7)] : random_code();
        end
        issue_request(rq, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Ran %0d requests over four idle patterns, %0d results checked.",
             requests_sent, results_checked);
    $display("List peaked at %0d entries; %0d appends hit a full list, %0d keys missed.",
             peak_fill, full_appends, key_misses);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
